[rtl/radio_module_config_command_parser_core_defines.svh]
// Assertion macros shared by the checker files.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef RADIO_MODULE_CONFIG_COMMAND_PARSER_CORE_DEFINES_SVH
`define RADIO_MODULE_CONFIG_COMMAND_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define RCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rcp_pkg.sv]
// ----------------------------------------------------------------------------
// rcp_pkg
// Types, command codes and constants of the configuration command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rcp_pkg;

  localparam int ParamBytesDef = 5;
  localparam int MaxParamBytes = 8;
  localparam int CountW        = 3;
  localparam int CfgIndexW     = 2;
  localparam int NbytesW       = 4;

  localparam logic [7:0] CmdSetSave = 8'hC0;
  localparam logic [7:0] CmdRead    = 8'hC1;
  localparam logic [7:0] CmdSet     = 8'hC2;
  localparam logic [7:0] CmdVersion = 8'hC3;
  localparam logic [7:0] CmdAux     = 8'hC4;

  localparam logic [7:0] ModelCodeRst   = 8'h32;
  localparam logic [7:0] VersionCodeRst = 8'h44;
  localparam logic [7:0] FeatureCodeRst = 8'h14;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_PERSIST = 2'd1,
    KIND_AUX     = 2'd2
  } out_kind_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MODEL   = 2'd0,
    CFG_VERSION = 2'd1,
    CFG_FEATURE = 2'd2
  } cfg_index_e;

  // Control part of one reply job handed from front to back.
  typedef struct packed {
    logic               is_aux;
    logic               persist;
    logic [NbytesW-1:0] nbytes;
  } job_ctl_t;

  // Bytes a job can carry: header plus the larger of parameter set and version set.
  function automatic int job_bytes(input int param_bytes);
    job_bytes = (param_bytes + 1 > 4) ? param_bytes + 1 : 4;
  endfunction

endpackage

`default_nettype wire

[rtl/rcp_if.sv]
// ----------------------------------------------------------------------------
// rcp_rx_if / rcp_tx_if
// Valid/ready channels for received host bytes and for parser results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcp_tx_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_kind, output out_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

[rtl/rcp_front.sv]
// ----------------------------------------------------------------------------
// rcp_front
// Frame parser: collects host bytes, stores parameters, issues reply jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_front #(
  parameter int ParamBytes = rcp_pkg::ParamBytesDef,
  parameter int JobBytes   = rcp_pkg::job_bytes(rcp_pkg::ParamBytesDef)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_fire_i,
  input  wire logic [7:0]                  rx_byte_i,
  input  wire logic [7:0]                  model_code_i,
  input  wire logic [7:0]                  version_code_i,
  input  wire logic [7:0]                  feature_code_i,
  output logic                             push_o,
  output rcp_pkg::job_ctl_t                push_ctl_o,
  output logic [JobBytes-1:0][7:0]         push_data_o
);
  import rcp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PARAMS = 2'd1,
    PH_TAIL   = 2'd2
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [7:0]                 cmd_q, cmd_d;
  logic [CountW-1:0]          count_q, count_d;
  logic                       tail_ok_q, tail_ok_d;
  logic [ParamBytes-1:0][7:0] frame_q, frame_d;
  logic [ParamBytes-1:0][7:0] params_q, params_d;

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    count_d     = count_q;
    tail_ok_d   = tail_ok_q;
    params_d    = params_q;
    push_o      = 1'b0;
    push_ctl_o  = '0;
    push_data_o = '0;
    // Frame buffer with the current byte dropped in at the fill position.
    for (int i = 0; i < ParamBytes; i++) begin
      frame_d[i] = (count_q == CountW'(i)) ? rx_byte_i : frame_q[i];
    end

    if (in_fire_i) begin
      case (phase_q)
        PH_PARAMS: begin
          if (count_q == CountW'(ParamBytes - 1)) begin
            params_d           = frame_d;
            push_o             = 1'b1;
            push_ctl_o.persist = (cmd_q == CmdSetSave);
            push_ctl_o.nbytes  = NbytesW'(ParamBytes + 1);
            push_data_o[0]     = cmd_q;
            for (int i = 0; i < ParamBytes; i++) begin
              push_data_o[i+1] = frame_d[i];
            end
            phase_d = PH_IDLE;
            count_d = '0;
          end else begin
            count_d = count_q + CountW'(1);
          end
        end
        PH_TAIL: begin
          if (count_q == '0) begin
            tail_ok_d = (rx_byte_i == cmd_q);
            count_d   = CountW'(1);
          end else begin
            if (tail_ok_q && (rx_byte_i == cmd_q)) begin
              push_o = 1'b1;
              case (cmd_q)
                CmdRead: begin
                  push_ctl_o.nbytes = NbytesW'(ParamBytes + 1);
                  push_data_o[0]    = CmdSetSave;
                  for (int i = 0; i < ParamBytes; i++) begin
                    push_data_o[i+1] = params_q[i];
                  end
                end
                CmdVersion: begin
                  push_ctl_o.nbytes = NbytesW'(4);
                  push_data_o[0]    = CmdVersion;
                  push_data_o[1]    = model_code_i;
                  push_data_o[2]    = version_code_i;
                  push_data_o[3]    = feature_code_i;
                end
                default: begin
                  push_ctl_o.is_aux = 1'b1;
                end
              endcase
            end
            phase_d = PH_IDLE;
            count_d = '0;
          end
        end
        default: begin
          count_d = '0;
          phase_d = PH_IDLE;
          if (rx_byte_i == CmdSetSave || rx_byte_i == CmdSet) begin
            cmd_d   = rx_byte_i;
            phase_d = PH_PARAMS;
          end else if (rx_byte_i == CmdRead || rx_byte_i == CmdVersion ||
                       rx_byte_i == CmdAux) begin
            cmd_d   = rx_byte_i;
            phase_d = PH_TAIL;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cmd_q     <= '0;
      count_q   <= '0;
      tail_ok_q <= 1'b0;
      params_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      count_q   <= count_d;
      tail_ok_q <= tail_ok_d;
      params_q  <= params_d;
    end
  end

  // Frame bytes are always written before they are read.
  always_ff @(posedge clk_i) begin
    if (in_fire_i && phase_q == PH_PARAMS) begin
      frame_q <= frame_d;
    end
  end

endmodule

`default_nettype wire

[rtl/rcp_queue.sv]
// ----------------------------------------------------------------------------
// rcp_queue
// Two-entry job queue between the parser and the reply sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_queue #(
  parameter int JobBytes = rcp_pkg::job_bytes(rcp_pkg::ParamBytesDef)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  rcp_pkg::job_ctl_t                push_ctl_i,
  input  wire logic [JobBytes-1:0][7:0]    push_data_i,
  output logic                             full_o,
  output logic                             head_valid_o,
  output rcp_pkg::job_ctl_t                head_ctl_o,
  output logic [JobBytes-1:0][7:0]         head_data_o,
  input  wire logic                        pop_i
);
  import rcp_pkg::*;

  localparam int Depth = 2;

  job_ctl_t                ctl_mem [Depth];
  logic [JobBytes-1:0][7:0] data_mem [Depth];
  logic                    wr_ptr_q, wr_ptr_d;
  logic                    rd_ptr_q, rd_ptr_d;
  logic [1:0]              fill_q, fill_d;

  assign full_o       = (fill_q == 2'(Depth));
  assign head_valid_o = (fill_q != '0);
  assign head_ctl_o   = ctl_mem[rd_ptr_q];
  assign head_data_o  = data_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_mem[wr_ptr_q]  <= push_ctl_i;
      data_mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/rcp_back.sv]
// ----------------------------------------------------------------------------
// rcp_back
// Reply sequencer: walks the head job and emits one result beat per cycle unless tx_if.ready stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcp_back #(
  parameter int JobBytes = rcp_pkg::job_bytes(rcp_pkg::ParamBytesDef)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        head_valid_i,
  input  rcp_pkg::job_ctl_t                head_ctl_i,
  input  wire logic [JobBytes-1:0][7:0]    head_data_i,
  output logic                             pop_o,
  rcp_tx_if.source                         tx_if
);
  import rcp_pkg::*;

  localparam int IdxW = $clog2(JobBytes);

  logic [NbytesW-1:0] step_q, step_d;
  logic [NbytesW-1:0] total;
  logic [NbytesW-1:0] idx;
  logic               advance;
  logic               last;
  out_kind_e          kind_d;
  logic [7:0]         byte_d;

  logic               valid_q, valid_d;
  out_kind_e          kind_q;
  logic [7:0]         byte_q;
  logic               last_q;

  assign advance = head_valid_i && (!valid_q || tx_if.ready);
  assign total   = head_ctl_i.is_aux ? NbytesW'(1)
                                     : head_ctl_i.nbytes + NbytesW'(head_ctl_i.persist);
  assign idx     = step_q - NbytesW'(head_ctl_i.persist);
  assign last    = (step_q + NbytesW'(1) == total);
  assign pop_o   = advance && last;

  always_comb begin
    if (head_ctl_i.is_aux) begin
      kind_d = KIND_AUX;
      byte_d = '0;
    end else if (head_ctl_i.persist && step_q == '0) begin
      kind_d = KIND_PERSIST;
      byte_d = '0;
    end else begin
      kind_d = KIND_TX;
      byte_d = head_data_i[idx[IdxW-1:0]];
    end
    step_d  = advance ? (last ? '0 : step_q + NbytesW'(1)) : step_q;
    valid_d = advance ? 1'b1 : (tx_if.ready ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // Hold the beat until it is taken.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last;
    end
  end

  assign tx_if.valid       = valid_q;
  assign tx_if.out_kind    = kind_q;
  assign tx_if.out_byte    = byte_q;
  assign tx_if.last_of_run = last_q;

endmodule

`default_nettype wire

[rtl/radio_module_config_command_parser_core.sv]
// Configuration command parser. One host byte is accepted per clock whenever
// the two-entry job queue has room, so bytes can arrive back to back. A byte
// that completes a valid frame queues a reply job; the reply sequencer then
// drives its results one beat per clock while tx_if.ready holds, from a
// registered output stage: up to PARAM_BYTES+2 beats for a parameter set with
// persist request, PARAM_BYTES+1 for a set or read, four for a version query
// and one for the aux request. Accept stalls only while the queue holds two
// jobs, the one being sequenced and one behind it, so the sustained rate is
// set by the sequencer: one result beat per cycle while tx_if.ready holds.
// Configuration registers (model, version, feature code) are written via
// cfg_we_i with cfg_index_i selecting the register; other indexes are ignored.
// ----------------------------------------------------------------------------
// radio_module_config_command_parser_core
// Top level: config registers, frame parser, job queue and reply sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_module_config_command_parser_core #(
  parameter int ParamBytes = rcp_pkg::ParamBytesDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rcp_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  wire logic [7:0]                      cfg_data_i,
  rcp_rx_if.sink                               rx_if,
  rcp_tx_if.source                             tx_if
);
  import rcp_pkg::*;

  localparam int JobBytes = job_bytes(ParamBytes);

  logic [7:0]               model_q, version_q, feature_q;
  logic                     in_fire;
  logic                     push;
  job_ctl_t                 push_ctl;
  logic [JobBytes-1:0][7:0] push_data;
  logic                     full;
  logic                     head_valid;
  job_ctl_t                 head_ctl;
  logic [JobBytes-1:0][7:0] head_data;
  logic                     pop;

  assign rx_if.ready = !full;
  assign in_fire     = rx_if.valid && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q   <= ModelCodeRst;
      version_q <= VersionCodeRst;
      feature_q <= FeatureCodeRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MODEL)   model_q   <= cfg_data_i;
      if (cfg_index_i == CFG_VERSION) version_q <= cfg_data_i;
      if (cfg_index_i == CFG_FEATURE) feature_q <= cfg_data_i;
    end
  end

  rcp_front #(
    .ParamBytes (ParamBytes),
    .JobBytes   (JobBytes)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .rx_byte_i      (rx_if.rx_byte),
    .model_code_i   (model_q),
    .version_code_i (version_q),
    .feature_code_i (feature_q),
    .push_o         (push),
    .push_ctl_o     (push_ctl),
    .push_data_o    (push_data)
  );

  rcp_queue #(
    .JobBytes (JobBytes)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ctl_i   (push_ctl),
    .push_data_i  (push_data),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_ctl_o   (head_ctl),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  rcp_back #(
    .JobBytes (JobBytes)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ctl_i   (head_ctl),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .tx_if        (tx_if)
  );

endmodule

`default_nettype wire

[rtl/rcp_checker.sv]
// ----------------------------------------------------------------------------
// rcp_checker
// Port-level checks on the result channel of the command parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radio_module_config_command_parser_core_defines.svh"

module rcp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       tx_valid_i,
  input wire logic       tx_ready_i,
  input wire logic [1:0] out_kind_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       last_of_run_i
);
  import rcp_pkg::*;

  // A stalled beat holds.
  `RCP_ASSERT_NXT(a_tx_hold, tx_valid_i && !tx_ready_i, tx_valid_i && $stable({out_kind_i, out_byte_i, last_of_run_i}), "result beat changed under stall")
  // Non-transmit results carry a zero byte.
  `RCP_ASSERT_IMP(a_kind_byte, tx_valid_i && out_kind_i != KIND_TX, out_byte_i == 8'h00, "non-transmit result with nonzero byte")
  // A persist request always precedes the echo.
  `RCP_ASSERT_IMP(a_persist_not_last, tx_valid_i && out_kind_i == KIND_PERSIST, !last_of_run_i, "persist request marked last")
  // An aux request stands alone.
  `RCP_ASSERT_IMP(a_aux_last, tx_valid_i && out_kind_i == KIND_AUX, last_of_run_i, "aux request not marked last")

endmodule

bind radio_module_config_command_parser_core rcp_checker u_rcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .tx_valid_i    (tx_if.valid),
  .tx_ready_i    (tx_if.ready),
  .out_kind_i    (tx_if.out_kind),
  .out_byte_i    (tx_if.out_byte),
  .last_of_run_i (tx_if.last_of_run)
);

`default_nettype wire

[dv/tb_radio_module_config_command_parser_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radio_module_config_command_parser_core
// Self-checking bench for the configuration command parser. Host bytes go in
// on the receive channel and reply beats come back on the transmit channel.
// A directed byte table runs first. Some of its replies are written out in
// the table and the rest are predicted. Random frames follow, with random
// idle gaps on both channels. The version code registers are rewritten
// between phases. Each reply beat is compared field by field with the
// oldest pending prediction.
// ----------------------------------------------------------------------------

module tb_radio_module_config_command_parser_core;
  import rcp_pkg::*;

  localparam int          PeriodNs     = 10;
  localparam int          ParamBytes   = ParamBytesDef;
  localparam int          PhaseItems   = 24;
  localparam int          SettleCycles = 32;
  localparam int          DrainLimit   = 20000;
  localparam longint      TimeoutNs    = 3_000_000;
  localparam logic [1:0]  CfgUnused    = 2'd3;  // index with no register behind it

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PARAMS = 2'd1,
    PH_TAIL   = 2'd2
  } parse_phase_e;

  typedef struct packed {
    out_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } reply_t;

  // One directed byte; typed rows carry n_typed replies from typed_replies.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [2:0] n_typed;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  rcp_rx_if rx_bus ();
  rcp_tx_if tx_bus ();

  radio_module_config_command_parser_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_if       (rx_bus),
    .tx_if       (tx_bus)
  );

  // Predictor state
  parse_phase_e phase_q;
  logic [7:0]   frame_cmd;
  logic [2:0]   frame_cnt;
  logic [7:0]   frame_buf [ParamBytes];
  logic [7:0]   stored_params [ParamBytes];
  logic [7:0]   model_code;
  logic [7:0]   version_code;
  logic [7:0]   feature_code;

  reply_t       step_replies [$];
  reply_t       pending_replies [$];
  reply_t       want;
  bit           mismatch;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  localparam stim_row_t DirectedRows [26] = '{
    '{8'h00, 1'b1, 3'd0}, '{8'hFF, 1'b1, 3'd0},
    // read before any set: all parameters still zero
    '{CmdRead, 1'b1, 3'd0}, '{CmdRead, 1'b1, 3'd0}, '{CmdRead, 1'b1, 3'd6},
    '{CmdVersion, 1'b1, 3'd0}, '{CmdVersion, 1'b1, 3'd0}, '{CmdVersion, 1'b1, 3'd4},
    '{CmdAux, 1'b1, 3'd0}, '{CmdAux, 1'b1, 3'd0}, '{CmdAux, 1'b1, 3'd1},
    // set and save; command bytes inside the frame are plain data
    '{CmdSetSave, 1'b1, 3'd0}, '{8'hFF, 1'b1, 3'd0}, '{8'h00, 1'b1, 3'd0},
    '{CmdRead, 1'b1, 3'd0}, '{CmdVersion, 1'b1, 3'd0}, '{8'hAA, 1'b1, 3'd7},
    '{CmdSet, 1'b0, 3'd0}, '{8'h01, 1'b0, 3'd0}, '{8'h02, 1'b0, 3'd0},
    '{8'h03, 1'b0, 3'd0}, '{8'h04, 1'b0, 3'd0}, '{8'h05, 1'b0, 3'd0},
    // tail mismatch: dropped with no reply
    '{CmdRead, 1'b1, 3'd0}, '{CmdRead, 1'b1, 3'd0}, '{CmdAux, 1'b1, 3'd0}
  };

  localparam reply_t TypedReplies [18] = '{
    '{KIND_TX, CmdSetSave, 1'b0}, '{KIND_TX, 8'h00, 1'b0}, '{KIND_TX, 8'h00, 1'b0},
    '{KIND_TX, 8'h00, 1'b0}, '{KIND_TX, 8'h00, 1'b0}, '{KIND_TX, 8'h00, 1'b1},
    '{KIND_TX, CmdVersion, 1'b0}, '{KIND_TX, ModelCodeRst, 1'b0},
    '{KIND_TX, VersionCodeRst, 1'b0}, '{KIND_TX, FeatureCodeRst, 1'b1},
    '{KIND_AUX, 8'h00, 1'b1},
    '{KIND_PERSIST, 8'h00, 1'b0}, '{KIND_TX, CmdSetSave, 1'b0}, '{KIND_TX, 8'hFF, 1'b0},
    '{KIND_TX, 8'h00, 1'b0}, '{KIND_TX, CmdRead, 1'b0}, '{KIND_TX, CmdVersion, 1'b0},
    '{KIND_TX, 8'hAA, 1'b1}
  };

  always #(PeriodNs / 2) clk_i = ~clk_i;

  function automatic void add_reply(input out_kind_e kind, input logic [7:0] data);
    step_replies.push_back('{kind, data, 1'b0});
  endfunction

  // Advance the parser by one host byte; the replies land in step_replies.
  function automatic void parse_byte(input logic [7:0] b);
    reply_t tail_r;
    step_replies.delete();
    case (phase_q)
      PH_PARAMS: begin
        if (frame_cnt < ParamBytes) frame_buf[frame_cnt] = b;
        frame_cnt = frame_cnt + 3'd1;
        if (frame_cnt == 3'd0 || frame_cnt >= ParamBytes) begin
          stored_params = frame_buf;
          if (frame_cmd == CmdSetSave) add_reply(KIND_PERSIST, 8'h00);
          add_reply(KIND_TX, frame_cmd);
          foreach (stored_params[i]) add_reply(KIND_TX, stored_params[i]);
          phase_q   = PH_IDLE;
          frame_cnt = '0;
        end
      end
      PH_TAIL: begin
        if (frame_cnt < ParamBytes) frame_buf[frame_cnt] = b;
        frame_cnt = frame_cnt + 3'd1;
        if (frame_cnt >= 3'd2) begin
          if (frame_buf[0] == frame_cmd && frame_buf[1] == frame_cmd) begin
            if (frame_cmd == CmdRead) begin
              add_reply(KIND_TX, CmdSetSave);
              foreach (stored_params[i]) add_reply(KIND_TX, stored_params[i]);
            end else if (frame_cmd == CmdVersion) begin
              add_reply(KIND_TX, CmdVersion);
              add_reply(KIND_TX, model_code);
              add_reply(KIND_TX, version_code);
              add_reply(KIND_TX, feature_code);
            end else begin
              add_reply(KIND_AUX, 8'h00);
            end
          end
          phase_q   = PH_IDLE;
          frame_cnt = '0;
        end
      end
      default: begin
        phase_q   = PH_IDLE;
        frame_cnt = '0;
        if (b == CmdSetSave || b == CmdSet) begin
          frame_cmd = b;
          phase_q   = PH_PARAMS;
        end else if (b == CmdRead || b == CmdVersion || b == CmdAux) begin
          frame_cmd = b;
          phase_q   = PH_TAIL;
        end
      end
    endcase
    if (step_replies.size() > 0) begin
      tail_r      = step_replies.pop_back();
      tail_r.last = 1'b1;
      step_replies.push_back(tail_r);
    end
  endfunction

  // Offer one byte, hold it until accepted, then run the predictor on it.
  task automatic send_byte(input logic [7:0] b, input bit predicted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_bus.ready) @(posedge clk_i);
    parse_byte(b);
    if (predicted) begin
      foreach (step_replies[i]) pending_replies.push_back(step_replies[i]);
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CFG_MODEL:   model_code   = val;
      CFG_VERSION: version_code = val;
      CFG_FEATURE: feature_code = val;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [7:0] m, input logic [7:0] v, input logic [7:0] f);
    cfg_write(CFG_MODEL, m);
    cfg_write(CFG_VERSION, v);
    cfg_write(CFG_FEATURE, f);
    cfg_write(CfgUnused, 8'($urandom_range(0, 255)));
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid, wait for every pending reply, then let the block settle.
  task automatic drain_replies();
    int unsigned guard;
    guard = 0;
    rx_bus.valid <= 1'b0;
    while (pending_replies.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_replies.size() != 0) begin
      $error("%0d expected beats never arrived", pending_replies.size());
      mismatch = 1'b1;
      pending_replies.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Reply checker and random receive-side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_bus.ready <= 1'b0;
    end else begin
      if (tx_bus.valid && tx_bus.ready) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected beat: out_kind %0d out_byte %02h last_of_run %0d",
                 tx_bus.out_kind, tx_bus.out_byte, tx_bus.last_of_run);
          mismatch = 1'b1;
        end else begin
          want = pending_replies.pop_front();
          if (tx_bus.out_kind !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, tx_bus.out_kind);
            mismatch = 1'b1;
          end
          if (tx_bus.out_byte !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, tx_bus.out_byte);
            mismatch = 1'b1;
          end
          if (tx_bus.last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, actual %0d", want.last, tx_bus.last_of_run);
            mismatch = 1'b1;
          end
        end
      end
      tx_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #(TimeoutNs);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned typed_idx;
    int unsigned items;
    int unsigned pick;
    int unsigned bad_pos;
    logic [7:0]  cmd;
    logic [7:0]  b;

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    tx_bus.ready   = 1'b0;
    mismatch       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    phase_q       = PH_IDLE;
    frame_cmd     = '0;
    frame_cnt     = '0;
    model_code    = ModelCodeRst;
    version_code  = VersionCodeRst;
    feature_code  = FeatureCodeRst;
    foreach (frame_buf[i]) frame_buf[i] = '0;
    foreach (stored_params[i]) stored_params[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, reset register values
    typed_idx = 0;
    foreach (DirectedRows[r]) begin
      send_byte(DirectedRows[r].rx, !DirectedRows[r].typed);
      if (DirectedRows[r].typed) begin
        repeat (DirectedRows[r].n_typed) begin
          pending_replies.push_back(TypedReplies[typed_idx]);
          typed_idx++;
        end
      end
    end
    drain_replies();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_codes(8'h00, 8'h00, 8'h00);
        end
        1: begin
          send_idle_pct = 81; recv_stall_pct = 0;
          set_codes(8'hFF, 8'hFF, 8'hFF);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 81;
          set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        end
        default: begin
          send_idle_pct = 24; recv_stall_pct = 24;
          set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        end
      endcase

      items = 0;
      while (items < PhaseItems) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          send_byte((pick <= 1) ? CmdSetSave : CmdSet, 1'b1);
          repeat (ParamBytes) begin
            // now and then put a command byte inside the frame
            if ($urandom_range(0, 7) == 0) b = CmdSetSave + 8'($urandom_range(0, 4));
            else b = 8'($urandom_range(0, 255));
            send_byte(b, 1'b1);
          end
          items += ParamBytes + 1;
        end else if (pick <= 7) begin
          case ($urandom_range(0, 2))
            0:       cmd = CmdRead;
            1:       cmd = CmdVersion;
            default: cmd = CmdAux;
          endcase
          send_byte(cmd, 1'b1);
          // broken tails corrupt the first, the second or both bytes
          bad_pos = (pick == 7) ? $urandom_range(0, 2) : 3;
          send_byte((bad_pos == 0 || bad_pos == 2) ? 8'($urandom_range(0, 255)) : cmd, 1'b1);
          send_byte((bad_pos == 1 || bad_pos == 2) ? 8'($urandom_range(0, 255)) : cmd, 1'b1);
          items += 3;
        end else begin
          // noise between frames, never a command byte
          b = 8'($urandom_range(0, 255));
          if (b >= CmdSetSave && b <= CmdAux) b = b ^ 8'h20;
          send_byte(b, 1'b1);
          items += 1;
        end
      end
      drain_replies();
    end

    if (!mismatch) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
